/* design/htrt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htrt_pkg: shared types and constants of the transmit retry tracker
// Widths, function and action codes, and the structs passed between the
// front end, the command queue, the register block and the slot engine.
// ----------------------------------------------------------------------------
package htrt_pkg;

   // Table geometry
   localparam int TX_SLOTS    = 4;
   localparam int ED_ID_BITS  = 32;
   localparam int SLOT_W      = (TX_SLOTS > 1) ? $clog2(TX_SLOTS) : 1;
   localparam int SCAN_W      = $clog2(TX_SLOTS + 1);

   // Fixed field widths
   localparam int FUNC_W      = 3;
   localparam int ACT_W       = 3;
   localparam int ED_PORT_W   = 32;
   localparam int COORD_W     = 6;
   localparam int SLOT_PORT_W = 2;
   localparam int CFG_W       = 8;
   localparam int ED_WIDE_W   = (ED_ID_BITS > ED_PORT_W) ? ED_ID_BITS : ED_PORT_W;

   // Configuration port
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   // Command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_SEND       = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ACK        = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_BUSY_ACK   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_COMMIT_ACK = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_TICK       = 3'd4;

   // Result action codes
   localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_DATA   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_COMMIT = 3'd2;
   localparam logic [ACT_W-1:0] ACT_FAIL   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_DONE   = 3'd4;
   localparam logic [ACT_W-1:0] ACT_FULL   = 3'd5;

   // Register reset values
   localparam logic [CFG_W-1:0] MAX_RETRIES_RST   = 8'd3;
   localparam logic [CFG_W-1:0] RETRY_TIMEOUT_RST = 8'd2;
   localparam logic [CFG_W-1:0] BUSY_TIMEOUT_RST  = 8'd3;

   typedef enum logic [2:0] {
      OP_SEND,
      OP_ACK,
      OP_BUSY_ACK,
      OP_COMMIT_ACK,
      OP_TICK
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic                   is_ed;
      logic [ED_ID_BITS-1:0]  ed_id;
      logic [COORD_W-1:0]     coord_id;
   } cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0]       action;
      logic [SLOT_PORT_W-1:0] slot_index;
      logic                   is_ed;
      logic [ED_PORT_W-1:0]   ed_id;
      logic [COORD_W-1:0]     coord_id;
   } result_type;

   typedef struct packed {
      logic [CFG_W-1:0] max_retries;
      logic [CFG_W-1:0] retry_timeout;
      logic [CFG_W-1:0] busy_timeout;
   } cfg_type;

   // Port identifier to stored identifier (truncate or zero-extend)
   function automatic logic [ED_ID_BITS-1:0] ed_to_slot(input logic [ED_PORT_W-1:0] id);
      logic [ED_WIDE_W-1:0] wide;
      wide = ED_WIDE_W'(id);
      return wide[ED_ID_BITS-1:0];
   endfunction

   // Stored identifier back to port width
   function automatic logic [ED_PORT_W-1:0] ed_to_port(input logic [ED_ID_BITS-1:0] id);
      logic [ED_WIDE_W-1:0] wide;
      wide = ED_WIDE_W'(id);
      return wide[ED_PORT_W-1:0];
   endfunction

   // Low bits of a slot number as reported on the result port
   function automatic logic [SLOT_PORT_W-1:0] slot_to_port(input logic [SLOT_W-1:0] s);
      logic [SLOT_W+SLOT_PORT_W-1:0] wide;
      wide = (SLOT_W + SLOT_PORT_W)'(s);
      return wide[SLOT_PORT_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* design/htrt_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htrt_regs: configuration registers
// APB-style register block holding retry count and the two timeouts.
// ----------------------------------------------------------------------------
module htrt_regs
   import htrt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   localparam logic [1:0] REG_MAX_RETRIES   = 2'd0;
   localparam logic [1:0] REG_RETRY_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_BUSY_TIMEOUT  = 2'd2;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in     = cfg_ff;
      csr_prdata = '0;
      unique case (reg_idx)
         REG_MAX_RETRIES: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.max_retries);
            if (wr_en) cfg_in.max_retries = csr_pwdata[CFG_W-1:0];
         end
         REG_RETRY_TIMEOUT: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.retry_timeout);
            if (wr_en) cfg_in.retry_timeout = csr_pwdata[CFG_W-1:0];
         end
         REG_BUSY_TIMEOUT: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.busy_timeout);
            if (wr_en) cfg_in.busy_timeout = csr_pwdata[CFG_W-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_retries   <= MAX_RETRIES_RST;
         cfg_ff.retry_timeout <= RETRY_TIMEOUT_RST;
         cfg_ff.busy_timeout  <= BUSY_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

/* design/htrt_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htrt_front: request intake and classification
// Takes request transactions, decodes the function code, drops unknown
// codes and hands classified commands to the queue.
// ----------------------------------------------------------------------------
module htrt_front
   import htrt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [FUNC_W-1:0]    req_func,
   input  wire logic                 req_peer_is_ed,
   input  wire logic [ED_PORT_W-1:0] req_peer_ed_id,
   input  wire logic [COORD_W-1:0]   req_peer_coord_id,
   output logic                      push_valid,
   input  wire logic                 push_ready,
   output cmd_type                   push_cmd
);

   logic    cmd_valid_ff, cmd_valid_in;
   cmd_type cmd_ff, cmd_in;
   cmd_type decoded;
   logic    known;

   assign req_ready  = !cmd_valid_ff || push_ready;
   assign push_valid = cmd_valid_ff;
   assign push_cmd   = cmd_ff;

   always_comb begin
      decoded.is_ed    = req_peer_is_ed;
      decoded.ed_id    = ed_to_slot(req_peer_ed_id);
      decoded.coord_id = req_peer_coord_id;
      decoded.op       = OP_SEND;
      known            = 1'b1;
      unique case (req_func)
         FUNC_SEND:       decoded.op = OP_SEND;
         FUNC_ACK:        decoded.op = OP_ACK;
         FUNC_BUSY_ACK:   decoded.op = OP_BUSY_ACK;
         FUNC_COMMIT_ACK: decoded.op = OP_COMMIT_ACK;
         FUNC_TICK:       decoded.op = OP_TICK;
         default:         known      = 1'b0;
      endcase
   end

   always_comb begin
      cmd_valid_in = cmd_valid_ff;
      cmd_in       = cmd_ff;
      if (req_valid && req_ready) begin
         // drop unknown codes here
         cmd_valid_in = known;
         cmd_in       = decoded;
      end else if (push_ready) begin
         cmd_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule
`default_nettype wire

/* design/htrt_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htrt_queue: command queue
// Short FIFO between the front end and the slot engine.
// ----------------------------------------------------------------------------
module htrt_queue
   import htrt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire cmd_type push_cmd,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output cmd_type      pop_cmd
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

/* design/htrt_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htrt_engine: slot table and scan sequencer
// Executes one command at a time by scanning the slot table, one slot per
// unstalled cycle; results go through a pending stage and an output register.
// ----------------------------------------------------------------------------
module htrt_engine
   import htrt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    pop_valid,
   output logic         pop_ready,
   input  wire cmd_type pop_cmd,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output result_type   rsp_res,
   output logic         rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [SCAN_W-1:0]     scan_ff, scan_in;
   logic                  hit_ff, hit_in;
   logic [CFG_W-1:0]      tick_ff, tick_in;
   logic                  pend_valid_ff, pend_valid_in;
   result_type            pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff, rsp_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [TX_SLOTS-1:0]   valid_ff, valid_in;
   logic                  is_ed_ff   [TX_SLOTS];
   logic                  is_ed_in   [TX_SLOTS];
   logic [ED_ID_BITS-1:0] ed_ff      [TX_SLOTS];
   logic [ED_ID_BITS-1:0] ed_in      [TX_SLOTS];
   logic [COORD_W-1:0]    coord_ff   [TX_SLOTS];
   logic [COORD_W-1:0]    coord_in   [TX_SLOTS];
   logic                  phase_ff   [TX_SLOTS];
   logic                  phase_in   [TX_SLOTS];
   logic [CFG_W-1:0]      retries_ff [TX_SLOTS];
   logic [CFG_W-1:0]      retries_in [TX_SLOTS];
   logic [CFG_W-1:0]      expiry_ff  [TX_SLOTS];
   logic [CFG_W-1:0]      expiry_in  [TX_SLOTS];

   logic [SLOT_W-1:0]     cur;
   logic                  cur_match;
   logic                  cur_expired;
   logic                  last_slot;
   logic                  out_free;
   logic [ACT_W-1:0]      act;
   logic                  finish;
   logic                  ev_valid;
   logic                  stall;
   logic                  full;
   result_type            ev_res;
   result_type            full_res;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_res   = rsp_ff;
   assign rsp_last  = rsp_last_ff;

   assign cur       = scan_ff[SLOT_W-1:0];
   assign last_slot = scan_ff == SCAN_W'(TX_SLOTS - 1);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign cur_match = valid_ff[cur] && (is_ed_ff[cur] == cmd_ff.is_ed) &&
                      (cmd_ff.is_ed ? (ed_ff[cur] == cmd_ff.ed_id)
                                    : (coord_ff[cur] == cmd_ff.coord_id));
   assign cur_expired = valid_ff[cur] && (expiry_ff[cur] == tick_ff);

   assign full = (cmd_ff.op == OP_SEND) && !hit_ff;

   always_comb begin
      full_res.action     = ACT_FULL;
      full_res.slot_index = '0;
      full_res.is_ed      = cmd_ff.is_ed;
      full_res.ed_id      = ed_to_port(cmd_ff.ed_id);
      full_res.coord_id   = cmd_ff.coord_id;
   end

   // Classify the slot under the scan pointer
   always_comb begin
      act    = ACT_NONE;
      finish = last_slot;
      case (cmd_ff.op)
         OP_SEND: begin
            if (!valid_ff[cur]) begin
               act    = ACT_DATA;
               finish = 1'b1;
            end
         end
         OP_ACK: begin
            if (cur_match) begin
               act    = ACT_COMMIT;
               finish = 1'b1;
            end
         end
         OP_BUSY_ACK: begin
            if (cur_match) finish = 1'b1;
         end
         OP_COMMIT_ACK: begin
            if (cur_match) begin
               act    = ACT_DONE;
               finish = 1'b1;
            end
         end
         OP_TICK: begin
            if (cur_expired) begin
               if (retries_ff[cur] == '0) act = ACT_FAIL;
               else act = phase_ff[cur] ? ACT_COMMIT : ACT_DATA;
            end
         end
         default: begin
            finish = 1'b1;
         end
      endcase
      ev_valid = act != ACT_NONE;
      stall    = ev_valid && pend_valid_ff && !out_free;

      ev_res.action     = act;
      ev_res.slot_index = slot_to_port(cur);
      if (cmd_ff.op == OP_SEND) begin
         ev_res.is_ed    = cmd_ff.is_ed;
         ev_res.ed_id    = ed_to_port(cmd_ff.ed_id);
         ev_res.coord_id = cmd_ff.coord_id;
      end else begin
         ev_res.is_ed    = is_ed_ff[cur];
         ev_res.ed_id    = ed_to_port(ed_ff[cur]);
         ev_res.coord_id = coord_ff[cur];
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      scan_in       = scan_ff;
      hit_in        = hit_ff;
      tick_in       = tick_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      valid_in      = valid_ff;
      is_ed_in      = is_ed_ff;
      ed_in         = ed_ff;
      coord_in      = coord_ff;
      phase_in      = phase_ff;
      retries_in    = retries_ff;
      expiry_in     = expiry_ff;
      pop_ready     = 1'b0;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cmd_in   = pop_cmd;
               scan_in  = '0;
               hit_in   = 1'b0;
               state_in = ST_SCAN;
               if (pop_cmd.op == OP_TICK) tick_in = tick_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               case (cmd_ff.op)
                  OP_SEND: begin
                     if (ev_valid) begin
                        valid_in[cur]   = 1'b1;
                        is_ed_in[cur]   = cmd_ff.is_ed;
                        ed_in[cur]      = cmd_ff.ed_id;
                        coord_in[cur]   = cmd_ff.coord_id;
                        phase_in[cur]   = 1'b0;
                        retries_in[cur] = cfg.max_retries;
                        expiry_in[cur]  = tick_ff + cfg.retry_timeout;
                        hit_in          = 1'b1;
                     end
                  end
                  OP_ACK: begin
                     if (cur_match) begin
                        retries_in[cur] = cfg.max_retries;
                        phase_in[cur]   = 1'b1;
                        expiry_in[cur]  = tick_ff + cfg.retry_timeout;
                     end
                  end
                  OP_BUSY_ACK: begin
                     if (cur_match) begin
                        retries_in[cur] = cfg.max_retries;
                        expiry_in[cur]  = tick_ff + cfg.busy_timeout;
                     end
                  end
                  OP_COMMIT_ACK: begin
                     if (cur_match) valid_in[cur] = 1'b0;
                  end
                  OP_TICK: begin
                     if (act == ACT_FAIL) begin
                        // drop every slot held for the failed peer
                        for (int j = 0; j < TX_SLOTS; j++) begin
                           if (valid_ff[j] && (is_ed_ff[j] == is_ed_ff[cur]) &&
                               (is_ed_ff[cur] ? (ed_ff[j] == ed_ff[cur])
                                              : (coord_ff[j] == coord_ff[cur]))) begin
                              valid_in[j] = 1'b0;
                           end
                        end
                        valid_in[cur] = 1'b0;
                     end else if (ev_valid) begin
                        retries_in[cur] = retries_ff[cur] - 1'b1;
                        expiry_in[cur]  = tick_ff + cfg.retry_timeout;
                     end
                  end
                  default: begin
                     hit_in = hit_ff;
                  end
               endcase

               // retire the previous result, hold the new one
               if (ev_valid) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = pend_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_in       = ev_res;
                  pend_valid_in = 1'b1;
               end

               scan_in = scan_ff + 1'b1;
               if (finish) state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (full || pend_valid_ff) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in        = full ? full_res : pend_ff;
                  rsp_last_in   = 1'b1;
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         valid_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         valid_ff      <= valid_in;
      end
      cmd_ff      <= cmd_in;
      scan_ff     <= scan_in;
      hit_ff      <= hit_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
      is_ed_ff    <= is_ed_in;
      ed_ff       <= ed_in;
      coord_ff    <= coord_in;
      phase_ff    <= phase_in;
      retries_ff  <= retries_in;
      expiry_ff   <= expiry_in;
   end

endmodule
`default_nettype wire

/* design/handshake_tx_retry_tracker_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// handshake_tx_retry_tracker_core: transmit side of a four-way link handshake
// Tracks pending sends in a small slot table and tells the transmitter when
// to send DATA or COMMIT, when a transaction is delivered and when a peer
// has failed.
// ----------------------------------------------------------------------------
// Each request transaction is a send, an ACK, a busy ACK, a COMMIT ACK or a
// timer tick; it yields zero to TX_SLOTS result transactions, the final one
// flagged by rsp_last. Unknown function codes are taken and dropped. A
// request passes a one-entry intake stage and a two-entry command queue, so
// intake keeps taking requests, until both are full, while the slot engine
// works or while a result waits at the output. The slot engine executes one
// command at a time and visits one table slot per cycle: a tick scans every
// slot, while a send, ACK, busy ACK or COMMIT ACK stops the scan at the
// first free or matching slot. A result stalled at the output holds the
// scan whenever a further result is produced. The retry count and both
// timeouts are programmed through the register port at byte offsets 0x0,
// 0x4 and 0x8; write them only while the block is idle.
// ----------------------------------------------------------------------------
module handshake_tx_retry_tracker_core
   import htrt_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   // request channel
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [FUNC_W-1:0]      req_func,
   input  wire logic                   req_peer_is_ed,
   input  wire logic [ED_PORT_W-1:0]   req_peer_ed_id,
   input  wire logic [COORD_W-1:0]     req_peer_coord_id,

   // result channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [ACT_W-1:0]            rsp_action,
   output logic [SLOT_PORT_W-1:0]      rsp_slot_index,
   output logic                        rsp_out_is_ed,
   output logic [ED_PORT_W-1:0]        rsp_out_ed_id,
   output logic [COORD_W-1:0]          rsp_out_coord_id,
   output logic                        rsp_last,

   // register port
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [CSR_DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   cfg_type    cfg;
   logic       push_valid, push_ready;
   cmd_type    push_cmd;
   logic       pop_valid, pop_ready;
   cmd_type    pop_cmd;
   result_type rsp_res;

   // Register block: retry count and timeouts
   htrt_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Intake: decode the function code, drop unknown codes
   htrt_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_peer_is_ed    (req_peer_is_ed),
      .req_peer_ed_id    (req_peer_ed_id),
      .req_peer_coord_id (req_peer_coord_id),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_cmd          (push_cmd)
   );

   // Decouple intake from the slot engine
   htrt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // Slot table, tick counter and result sequencing
   htrt_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_res   (rsp_res),
      .rsp_last  (rsp_last)
   );

   // Unpack the result transaction onto its ports
   assign rsp_action       = rsp_res.action;
   assign rsp_slot_index   = rsp_res.slot_index;
   assign rsp_out_is_ed    = rsp_res.is_ed;
   assign rsp_out_ed_id    = rsp_res.ed_id;
   assign rsp_out_coord_id = rsp_res.coord_id;

endmodule
`default_nettype wire
